### src/tam_pkg.sv
`default_nettype none

package tam_pkg;

    localparam int RAW_W        = 16;
    localparam int CTR_W        = RAW_W + 1;
    localparam int PROD_W       = 2 * CTR_W;
    localparam int CW           = PROD_W + 2;
    localparam int ANGLE_W      = 16;
    localparam int Z_W          = ANGLE_W + 1;
    localparam int RING_SIZE    = 10;
    localparam int POS_W        = 4;
    localparam int SUM_W        = 20;
    localparam int MAG_W        = 19;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;
    localparam int RECIP_W      = 16;
    localparam int DIV10_SHIFT  = 19;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    localparam logic [RAW_W-1:0]   Y_LOW_RST  = 16'd12300;
    localparam logic [RAW_W-1:0]   Y_HIGH_RST = 16'd32300;
    localparam logic [RAW_W-1:0]   Z_LOW_RST  = 16'd8300;
    localparam logic [RAW_W-1:0]   Z_HIGH_RST = 16'd29300;

    localparam logic [RECIP_W-1:0] DIV10_RECIP = 16'd52429;
    localparam logic [POS_W-1:0]   POS_LAST    = POS_W'(RING_SIZE - 1);
    localparam logic [STEP_W-1:0]  STEP_LAST   = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [QCNT_W-1:0]  QFULL       = QCNT_W'(QDEPTH);

    localparam logic signed [Z_W-1:0] HALF_PI         = 17'sd12868;
    localparam logic signed [Z_W-1:0] ANGLE_LIMIT     = 17'sd25736;
    localparam logic signed [Z_W-1:0] NEG_HALF_PI     = -17'sd12868;
    localparam logic signed [Z_W-1:0] NEG_ANGLE_LIMIT = -17'sd25736;

    typedef enum logic [1:0] {
        REG_Y_LOW  = 2'd0,
        REG_Y_HIGH = 2'd1,
        REG_Z_LOW  = 2'd2,
        REG_Z_HIGH = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ROT,
        B_RING,
        B_DIV
    } back_state_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] y;
        logic signed [PROD_W-1:0] x;
        logic                     x_zero;
        logic                     y_zero;
        logic                     x_neg;
        logic                     y_neg;
    } vec_t;

    function automatic logic signed [Z_W-1:0] step_angle(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] a;
        unique case (i)
            4'd0:    a = 17'sd6434;
            4'd1:    a = 17'sd3798;
            4'd2:    a = 17'sd2007;
            4'd3:    a = 17'sd1019;
            4'd4:    a = 17'sd511;
            4'd5:    a = 17'sd256;
            4'd6:    a = 17'sd128;
            4'd7:    a = 17'sd64;
            4'd8:    a = 17'sd32;
            4'd9:    a = 17'sd16;
            4'd10:   a = 17'sd8;
            4'd11:   a = 17'sd4;
            4'd12:   a = 17'sd2;
            4'd13:   a = 17'sd1;
            default: a = 17'sd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### src/tilt_angle_moving_average.sv
`default_nettype none

// Tilt angle from a Y/Z accelerometer pair, averaged over the last ten samples.
// Each s_ word carries y_raw and z_raw; both are centred on their range
// midpoint and the angle atan2 of the span-scaled pair is found by a 16-step
// CORDIC, giving signed Q3.13 radians saturated to +-pi. Every input word gives
// exactly one m_ word: the mean of the ten most recent angles (ring cleared to
// zero at reset), truncated toward zero. The range registers (0 y_low, 1 y_high,
// 2 z_low, 3 z_high; reset 12300, 32300, 8300, 29300) are written through
// cfg_wen/cfg_addr/cfg_wdata and must only change while the block is idle.
// The single shared CORDIC stage sets the rate: each word goes through pop,
// 16 rotations, ring update and divide in turn, the rotations skipped when both
// products are zero, and the next word is popped only after the last is done.
// m_tvalid is raised from the divide state once the result side is free.
// A two-word queue after the input stage lets new words be taken while the
// CORDIC is busy or a result waits to be read.
module tilt_angle_moving_average (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [31:0]               s_tdata,    // y_raw[15:0], z_raw[31:16]
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [tam_pkg::ANGLE_W-1:0]    m_tdata,    // tilt_angle[15:0]
    input  wire logic                      cfg_wen,
    input  wire logic [1:0]                cfg_addr,
    input  wire logic [tam_pkg::RAW_W-1:0] cfg_wdata
);

    logic          push_valid, push_ready, pop_valid, pop_ready;
    tam_pkg::vec_t push_data, pop_data;

    tam_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_wen    (cfg_wen),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tam_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tam_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

### src/tam_front.sv
`default_nettype none

module tam_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,    // y_raw[15:0], z_raw[31:16]
    input  wire logic                          cfg_wen,
    input  wire logic [1:0]                    cfg_addr,
    input  wire logic [tam_pkg::RAW_W-1:0]     cfg_wdata,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output tam_pkg::vec_t                      push_data
);

    logic [tam_pkg::RAW_W-1:0] y_low_reg, y_high_reg, z_low_reg, z_high_reg;

    logic                              hold_valid_reg, hold_valid_next;
    logic signed [tam_pkg::CTR_W-1:0]  yc_reg, zc_reg, yspan_reg, zspan_reg;
    logic signed [tam_pkg::CTR_W-1:0]  yc_next, zc_next, yspan_next, zspan_next;

    logic [tam_pkg::CTR_W-1:0]         y_mid_sum, z_mid_sum;
    logic                              accept;

    logic signed [tam_pkg::PROD_W-1:0] yc_ext, zc_ext, yspan_ext, zspan_ext;
    logic signed [tam_pkg::PROD_W-1:0] prod_x, prod_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_low_reg  <= tam_pkg::Y_LOW_RST;
            y_high_reg <= tam_pkg::Y_HIGH_RST;
            z_low_reg  <= tam_pkg::Z_LOW_RST;
            z_high_reg <= tam_pkg::Z_HIGH_RST;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                tam_pkg::REG_Y_LOW:  y_low_reg  <= cfg_wdata;
                tam_pkg::REG_Y_HIGH: y_high_reg <= cfg_wdata;
                tam_pkg::REG_Z_LOW:  z_low_reg  <= cfg_wdata;
                tam_pkg::REG_Z_HIGH: z_high_reg <= cfg_wdata;
            endcase
        end
    end

    // centre on the range midpoint, keep the spans with their sign
    always_comb begin
        y_mid_sum  = {1'b0, y_low_reg} + {1'b0, y_high_reg};
        z_mid_sum  = {1'b0, z_low_reg} + {1'b0, z_high_reg};
        yc_next    = $signed({1'b0, s_tdata[15:0]}) - $signed({1'b0, y_mid_sum[16:1]});
        zc_next    = $signed({1'b0, s_tdata[31:16]}) - $signed({1'b0, z_mid_sum[16:1]});
        yspan_next = $signed({1'b0, y_high_reg}) - $signed({1'b0, y_low_reg});
        zspan_next = $signed({1'b0, z_high_reg}) - $signed({1'b0, z_low_reg});
    end

    assign s_tready = !hold_valid_reg || push_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
        end else if (push_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            yc_reg    <= yc_next;
            zc_reg    <= zc_next;
            yspan_reg <= yspan_next;
            zspan_reg <= zspan_next;
        end
    end

    assign yc_ext    = {{(tam_pkg::PROD_W-tam_pkg::CTR_W){yc_reg[tam_pkg::CTR_W-1]}}, yc_reg};
    assign zc_ext    = {{(tam_pkg::PROD_W-tam_pkg::CTR_W){zc_reg[tam_pkg::CTR_W-1]}}, zc_reg};
    assign yspan_ext = {{(tam_pkg::PROD_W-tam_pkg::CTR_W){yspan_reg[tam_pkg::CTR_W-1]}},
                        yspan_reg};
    assign zspan_ext = {{(tam_pkg::PROD_W-tam_pkg::CTR_W){zspan_reg[tam_pkg::CTR_W-1]}},
                        zspan_reg};

    assign prod_x = yc_ext * zspan_ext;
    assign prod_y = zc_ext * yspan_ext;

    // classify from the factor signs, off the multiplier path
    always_comb begin
        push_data.x      = prod_x;
        push_data.y      = prod_y;
        push_data.x_zero = (yc_reg == '0) || (zspan_reg == '0);
        push_data.y_zero = (zc_reg == '0) || (yspan_reg == '0);
        push_data.x_neg  = !push_data.x_zero &&
                           (yc_reg[tam_pkg::CTR_W-1] ^ zspan_reg[tam_pkg::CTR_W-1]);
        push_data.y_neg  = !push_data.y_zero &&
                           (zc_reg[tam_pkg::CTR_W-1] ^ yspan_reg[tam_pkg::CTR_W-1]);
    end

    assign push_valid = hold_valid_reg;

endmodule

`default_nettype wire

### src/tam_queue.sv
`default_nettype none

module tam_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire tam_pkg::vec_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output tam_pkg::vec_t      pop_data
);

    tam_pkg::vec_t                entry_reg [tam_pkg::QDEPTH];
    logic [tam_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tam_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tam_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                         push, pop;

    assign push_ready = (count_reg != tam_pkg::QFULL);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= tam_pkg::QFULL)
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

### src/tam_back.sv
`default_nettype none

module tam_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       pop_valid,
    output logic                            pop_ready,
    input  wire tam_pkg::vec_t              pop_data,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [tam_pkg::ANGLE_W-1:0]     m_tdata     // tilt_angle[15:0]
);

    tam_pkg::back_state_t               state_reg, state_next;
    logic [tam_pkg::STEP_W-1:0]         step_reg, step_next;
    logic signed [tam_pkg::CW-1:0]      x_reg, x_next, y_reg, y_next;
    logic signed [tam_pkg::Z_W-1:0]     z_reg, z_next;

    logic signed [tam_pkg::ANGLE_W-1:0] ring_reg [tam_pkg::RING_SIZE];
    logic [tam_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic signed [tam_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic                               ring_we;

    logic                               out_valid_reg, out_valid_next;
    logic [tam_pkg::ANGLE_W-1:0]        out_data_reg;
    logic                               out_load;

    logic signed [tam_pkg::CW-1:0]      x_in, y_in, xs, ys;
    logic signed [tam_pkg::Z_W-1:0]     z_clamp;
    logic signed [tam_pkg::ANGLE_W-1:0] angle;
    logic signed [tam_pkg::ANGLE_W-1:0] ring_old;

    logic                               sum_neg;
    logic signed [tam_pkg::SUM_W-1:0]   sum_abs;
    logic [tam_pkg::MAG_W+tam_pkg::RECIP_W-1:0] quot_prod;
    logic [tam_pkg::ANGLE_W-1:0]        quot, avg;

    assign x_in = {{(tam_pkg::CW-tam_pkg::PROD_W){pop_data.x[tam_pkg::PROD_W-1]}}, pop_data.x};
    assign y_in = {{(tam_pkg::CW-tam_pkg::PROD_W){pop_data.y[tam_pkg::PROD_W-1]}}, pop_data.y};
    assign xs   = x_reg >>> step_reg;
    assign ys   = y_reg >>> step_reg;

    always_comb begin
        if (z_reg > tam_pkg::ANGLE_LIMIT) begin
            z_clamp = tam_pkg::ANGLE_LIMIT;
        end else if (z_reg < tam_pkg::NEG_ANGLE_LIMIT) begin
            z_clamp = tam_pkg::NEG_ANGLE_LIMIT;
        end else begin
            z_clamp = z_reg;
        end
        angle    = z_clamp[tam_pkg::ANGLE_W-1:0];
        ring_old = ring_reg[pos_reg];
    end

    // divide by the ring size: magnitude times reciprocal, sign restored
    always_comb begin
        sum_neg   = sum_reg[tam_pkg::SUM_W-1];
        sum_abs   = sum_neg ? -sum_reg : sum_reg;
        quot_prod = sum_abs[tam_pkg::MAG_W-1:0] * tam_pkg::DIV10_RECIP;
        quot      = quot_prod[tam_pkg::DIV10_SHIFT +: tam_pkg::ANGLE_W];
        avg       = sum_neg ? -quot : quot;
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        ring_we    = 1'b0;
        out_load   = 1'b0;
        pop_ready  = 1'b0;
        unique case (state_reg)
            tam_pkg::B_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    step_next = '0;
                    if (pop_data.x_zero && pop_data.y_zero) begin
                        z_next     = '0;
                        state_next = tam_pkg::B_RING;
                    end else begin
                        state_next = tam_pkg::B_ROT;
                        if (pop_data.x_neg && !pop_data.y_neg) begin
                            x_next = y_in;
                            y_next = -x_in;
                            z_next = tam_pkg::HALF_PI;
                        end else if (pop_data.x_neg) begin
                            x_next = -y_in;
                            y_next = x_in;
                            z_next = tam_pkg::NEG_HALF_PI;
                        end else begin
                            x_next = x_in;
                            y_next = y_in;
                            z_next = '0;
                        end
                    end
                end
            end
            tam_pkg::B_ROT: begin
                if (!y_reg[tam_pkg::CW-1]) begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + tam_pkg::step_angle(step_reg);
                end else begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - tam_pkg::step_angle(step_reg);
                end
                step_next = step_reg + 1'b1;
                if (step_reg == tam_pkg::STEP_LAST) begin
                    state_next = tam_pkg::B_RING;
                end
            end
            tam_pkg::B_RING: begin
                ring_we  = 1'b1;
                sum_next = sum_reg
                    - {{(tam_pkg::SUM_W-tam_pkg::ANGLE_W){ring_old[tam_pkg::ANGLE_W-1]}},
                       ring_old}
                    + {{(tam_pkg::SUM_W-tam_pkg::ANGLE_W){angle[tam_pkg::ANGLE_W-1]}}, angle};
                pos_next = (pos_reg == tam_pkg::POS_LAST) ? '0 : pos_reg + 1'b1;
                state_next = tam_pkg::B_DIV;
            end
            tam_pkg::B_DIV: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = tam_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = tam_pkg::B_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tam_pkg::B_IDLE;
            step_reg      <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (out_load) begin
            out_data_reg <= avg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tam_pkg::RING_SIZE; i++) begin
                ring_reg[i] <= '0;
            end
        end else if (ring_we) begin
            ring_reg[pos_reg] <= angle;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= tam_pkg::POS_LAST)
        else $error("ring position out of range");

    a_pop_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready) |=> (state_reg == tam_pkg::B_ROT ||
                                      state_reg == tam_pkg::B_RING))
        else $error("popped word not taken up");

    a_rot_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tam_pkg::B_ROT && step_reg == tam_pkg::STEP_LAST)
            |=> state_reg == tam_pkg::B_RING)
        else $error("rotation did not end after last step");

    a_out_from_div: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == tam_pkg::B_DIV)
        else $error("result raised outside divide state");
`endif

endmodule

`default_nettype wire

### sim/tilt_angle_checker.sv
`default_nettype none

module tilt_angle_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,    // y_raw[15:0], z_raw[31:16]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,    // tilt_angle[15:0]
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    output int               fail_count,
    output int               words_pending
);

    localparam int     FRAC_BITS   = 13;
    localparam int     TAPS        = 10;
    localparam int     STEPS       = 16;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_PI      = 64'sd3373259426;

    logic [15:0] y_low, y_high, z_low, z_high;
    int          angle_ring [TAPS];
    int          ring_pos;
    int          angle_sum;
    int          mismatches;
    logic [15:0] expected_tilt [$];

    function automatic longint q30_round(input longint q30);
        return (q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    endfunction

    function automatic longint rotation_angle(input int i);
        longint q30;
        case (i)
            0:       q30 = 64'sd843314856;
            1:       q30 = 64'sd497837829;
            2:       q30 = 64'sd263043836;
            3:       q30 = 64'sd133525158;
            4:       q30 = 64'sd67021686;
            5:       q30 = 64'sd33543515;
            6:       q30 = 64'sd16775850;
            7:       q30 = 64'sd8388437;
            8:       q30 = 64'sd4194282;
            9:       q30 = 64'sd2097149;
            default: q30 = (64'sd1 <<< (30 - i)) - 1;
        endcase
        return q30_round(q30);
    endfunction

    // vectoring CORDIC: angle of (vx, vy), saturated to +-pi
    function automatic int vector_angle(input longint vy, input longint vx);
        longint ay, ax, az, lim, sx, sy, t;
        ay  = vy;
        ax  = vx;
        az  = 0;
        lim = q30_round(Q30_PI);
        if (ax == 0 && ay == 0)
            return 0;
        if (ax < 0) begin
            t = ax;
            if (ay >= 0) begin
                ax = ay;
                ay = -t;
                az = q30_round(Q30_HALF_PI);
            end else begin
                ax = -ay;
                ay = t;
                az = -q30_round(Q30_HALF_PI);
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            sx = ax >>> i;
            sy = ay >>> i;
            if (ay >= 0) begin
                ax = ax + sy;
                ay = ay - sx;
                az = az + rotation_angle(i);
            end else begin
                ax = ax - sy;
                ay = ay + sx;
                az = az - rotation_angle(i);
            end
        end
        if (az > lim)
            az = lim;
        if (az < -lim)
            az = -lim;
        return int'(az);
    endfunction

    function automatic logic [15:0] fold_into_average(input logic [15:0] y_raw,
                                                      input logic [15:0] z_raw);
        longint yc, zc, yspan, zspan;
        int     angle;
        int     avg;
        yc    = longint'(y_raw) - ((longint'(y_low) + longint'(y_high)) >>> 1);
        zc    = longint'(z_raw) - ((longint'(z_low) + longint'(z_high)) >>> 1);
        yspan = longint'(y_high) - longint'(y_low);
        zspan = longint'(z_high) - longint'(z_low);
        angle = vector_angle(zc * yspan, yc * zspan);
        angle_sum = angle_sum - angle_ring[ring_pos] + angle;
        angle_ring[ring_pos] = angle;
        ring_pos = (ring_pos == TAPS - 1) ? 0 : ring_pos + 1;
        avg = angle_sum / TAPS;
        return avg[15:0];
    endfunction

    always @(posedge aclk) begin
        logic [15:0] want;
        if (!aresetn) begin
            y_low     = tam_pkg::Y_LOW_RST;
            y_high    = tam_pkg::Y_HIGH_RST;
            z_low     = tam_pkg::Z_LOW_RST;
            z_high    = tam_pkg::Z_HIGH_RST;
            ring_pos  = 0;
            angle_sum = 0;
            mismatches = 0;
            foreach (angle_ring[i])
                angle_ring[i] = 0;
            expected_tilt.delete();
            fail_count    <= 0;
            words_pending <= 0;
        end else begin
            if (cfg_wen) begin
                case (tam_pkg::cfg_reg_t'(cfg_addr))
                    tam_pkg::REG_Y_LOW:  y_low  = cfg_wdata;
                    tam_pkg::REG_Y_HIGH: y_high = cfg_wdata;
                    tam_pkg::REG_Z_LOW:  z_low  = cfg_wdata;
                    tam_pkg::REG_Z_HIGH: z_high = cfg_wdata;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_tilt.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: tilt_angle %0d",
                                 $signed(m_tdata));
                end else begin
                    want = expected_tilt.pop_front();
                    if (m_tdata !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("tilt_angle mismatch: expected %0d, got %0d",
                                     $signed(want), $signed(m_tdata));
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_tilt.push_back(fold_into_average(s_tdata[15:0], s_tdata[31:16]));
            words_pending <= expected_tilt.size();
            fail_count    <= mismatches;
        end
    end

endmodule

`default_nettype wire

### sim/tilt_angle_moving_average_tb.sv
`default_nettype none

module tilt_angle_moving_average_tb;

    localparam int N_CORNERS = 19;
    localparam int N_PHASES  = 10;
    localparam int PER_PHASE = 190;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_wen   = 1'b0;
    logic [1:0]  cfg_addr  = tam_pkg::REG_Y_LOW;
    logic [15:0] cfg_wdata = '0;

    int fail_count;
    int words_pending;
    bit no_idle = 1'b0;
    int burst_left = 0;

    logic [15:0] cur_y_lo = tam_pkg::Y_LOW_RST;
    logic [15:0] cur_y_hi = tam_pkg::Y_HIGH_RST;
    logic [15:0] cur_z_lo = tam_pkg::Z_LOW_RST;
    logic [15:0] cur_z_hi = tam_pkg::Z_HIGH_RST;

    logic [15:0] corner_y [N_CORNERS] = '{
        16'd22300, 16'd0, 16'd65535, 16'd0, 16'd65535, 16'd12300, 16'd32300,
        16'd22300, 16'd22300, 16'd12300, 16'd12300, 16'd32300, 16'd32300,
        16'd22301, 16'd22299, 16'd22300, 16'd22300, 16'd22299, 16'd22299
    };
    logic [15:0] corner_z [N_CORNERS] = '{
        16'd18800, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd18800, 16'd18800,
        16'd29300, 16'd8300, 16'd29300, 16'd8300, 16'd29300, 16'd8300,
        16'd18800, 16'd18800, 16'd18801, 16'd18799, 16'd18801, 16'd18799
    };

    always #5 aclk = ~aclk;

    tilt_angle_moving_average dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    tilt_angle_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    task automatic send_sample(input logic [15:0] y_raw, input logic [15:0] z_raw);
        int gap;
        if (burst_left > 0)
            burst_left--;
        else if ($urandom_range(0, 30) == 0)
            burst_left = $urandom_range(15, 40);
        no_idle = (burst_left > 0);
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z_raw, y_raw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
    endtask

    task automatic set_reg(input tam_pkg::cfg_reg_t idx, input logic [15:0] value);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic write_ranges();
        set_reg(tam_pkg::REG_Y_LOW,  cur_y_lo);
        set_reg(tam_pkg::REG_Y_HIGH, cur_y_hi);
        set_reg(tam_pkg::REG_Z_LOW,  cur_z_lo);
        set_reg(tam_pkg::REG_Z_HIGH, cur_z_hi);
        cfg_wen <= 1'b0;
    endtask

    // bias towards the axes and the origin, where the quadrant logic turns
    task automatic random_sample();
        int          y_mid, z_mid;
        logic [15:0] y_raw, z_raw;
        y_mid = (int'(cur_y_lo) + int'(cur_y_hi)) >> 1;
        z_mid = (int'(cur_z_lo) + int'(cur_z_hi)) >> 1;
        y_raw = 16'($urandom_range(0, 65535));
        z_raw = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 9))
            0: y_raw = 16'(y_mid);
            1: z_raw = 16'(z_mid);
            2: begin
                y_raw = 16'(y_mid + int'($urandom_range(0, 6)) - 3);
                z_raw = 16'(z_mid + int'($urandom_range(0, 6)) - 3);
            end
            3: begin
                y_raw = 16'(y_mid + int'($urandom_range(0, 600)) - 300);
                z_raw = 16'(z_mid + int'($urandom_range(0, 600)) - 300);
            end
            default: ;
        endcase
        if ($urandom_range(0, 60) == 0)
            drain_results();
        send_sample(y_raw, z_raw);
    endtask

    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        #10_000_000;
        $display("tilt_angle_moving_average regression: fail");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_CORNERS; i++)
            send_sample(corner_y[i], corner_z[i]);

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            case (p)
                0: begin
                    cur_y_lo = tam_pkg::Y_LOW_RST; cur_y_hi = tam_pkg::Y_HIGH_RST;
                    cur_z_lo = tam_pkg::Z_LOW_RST; cur_z_hi = tam_pkg::Z_HIGH_RST;
                end
                1: begin
                    cur_y_lo = 16'd0; cur_y_hi = 16'd65535;
                    cur_z_lo = 16'd0; cur_z_hi = 16'd65535;
                end
                2: begin
                    cur_y_lo = 16'd65535; cur_y_hi = 16'd0;
                    cur_z_lo = 16'd65535; cur_z_hi = 16'd0;
                end
                3: begin
                    cur_y_lo = tam_pkg::Y_HIGH_RST; cur_y_hi = tam_pkg::Y_LOW_RST;
                    cur_z_lo = tam_pkg::Z_LOW_RST;  cur_z_hi = tam_pkg::Z_HIGH_RST;
                end
                4: begin
                    cur_y_lo = 16'd20000;          cur_y_hi = 16'd20000;
                    cur_z_lo = tam_pkg::Z_LOW_RST; cur_z_hi = tam_pkg::Z_HIGH_RST;
                end
                5: begin
                    cur_y_lo = tam_pkg::Y_LOW_RST; cur_y_hi = tam_pkg::Y_HIGH_RST;
                    cur_z_lo = 16'd5000;           cur_z_hi = 16'd5000;
                end
                6: begin
                    cur_y_lo = 16'd0;     cur_y_hi = 16'd0;
                    cur_z_lo = 16'd65535; cur_z_hi = 16'd65535;
                end
                default: begin
                    cur_y_lo = 16'($urandom_range(0, 65535));
                    cur_y_hi = 16'($urandom_range(0, 65535));
                    cur_z_lo = 16'($urandom_range(0, 65535));
                    cur_z_hi = 16'($urandom_range(0, 65535));
                end
            endcase
            write_ranges();
            repeat (PER_PHASE) random_sample();
        end

        drain_results();
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && words_pending == 0)
            $display("tilt_angle_moving_average regression: pass");
        else
            $display("tilt_angle_moving_average regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
